### hw/rtl/cdtb_pkg.sv
// cdtb_pkg: shared types, codes and sizing for the countdown timer bank.
// Depends on nothing; imported by countdown_timer_bank.
`default_nettype none

package cdtb_pkg;

  // Bank sizing
  localparam int TIMERS        = 16;
  localparam int DURATION_BITS = 24;
  localparam int GROUP_BITS    = 8;
  localparam int IDX_W         = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int CNT_W         = $clog2(TIMERS + 1);

  // Fixed field widths of the command and result beats
  localparam int SLOT_W  = 4;
  localparam int DUR_W   = 24;
  localparam int GRP_W   = 8;
  localparam int ELAP_W  = 16;
  localparam int COUNT_W = 5;

  typedef enum logic [2:0] {
    CMD_ADD         = 3'd0,
    CMD_REMOVE      = 3'd1,
    CMD_START       = 3'd2,
    CMD_PAUSE       = 3'd3,
    CMD_EDIT        = 3'd4,
    CMD_TICK        = 3'd5,
    CMD_START_GROUP = 3'd6,
    CMD_QUERY       = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_DONE     = 3'd0,
    KIND_REJECTED = 3'd1,
    KIND_FINISHED = 3'd2,
    KIND_NEXT     = 3'd3,
    KIND_NONE     = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    TMR_PAUSED   = 2'd0,
    TMR_RUNNING  = 2'd1,
    TMR_FINISHED = 2'd2
  } tmr_status_t;

  typedef enum logic [1:0] {
    SEQ_IDLE  = 2'd0,
    SEQ_CMD   = 2'd1,
    SEQ_SWEEP = 2'd2,
    SEQ_DONE  = 2'd3
  } seq_state_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [SLOT_W-1:0]   slot;
    logic [DUR_W-1:0]    duration;
    logic [GRP_W-1:0]    group_id;
    logic [ELAP_W-1:0]   elapsed;
  } req_t;

  typedef struct packed {
    kind_t               kind;
    logic [SLOT_W-1:0]   slot_out;
    logic [DUR_W-1:0]    remaining_out;
    logic [COUNT_W-1:0]  entry_count;
    logic                last;
  } rsp_t;

  typedef struct packed {
    logic [DURATION_BITS-1:0] duration;
    logic [DURATION_BITS-1:0] remaining;
    tmr_status_t              status;
    logic [GROUP_BITS-1:0]    group;
  } entry_t;

  // Start one timer: a finished timer reloads before it runs again
  function automatic entry_t start_entry(entry_t e);
    entry_t r;
    r = e;
    if (e.status == TMR_FINISHED) begin
      r.remaining = e.duration;
    end
    r.status = TMR_RUNNING;
    return r;
  endfunction

  // Build one result beat
  function automatic rsp_t make_rsp(kind_t k, logic [IDX_W-1:0] idx,
                                    logic [DURATION_BITS-1:0] rem,
                                    logic [CNT_W-1:0] cnt, logic lst);
    rsp_t r;
    r.kind          = k;
    r.slot_out      = SLOT_W'(idx);
    r.remaining_out = DUR_W'(rem);
    r.entry_count   = COUNT_W'(cnt);
    r.last          = lst;
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/countdown_timer_bank.sv
// countdown_timer_bank: compact list of countdown timers with a sweep sequencer.
// Depends on cdtb_pkg (types, codes, entry helpers).
//
//   port          dir  beat marker        contents
//   request       in   start && !busy     command, slot, duration, group, elapsed
//   result        out  result_valid       kind, slot, remaining, count, last
//
// Add, edit and rejected commands: the result is registered from the decode state.
// Sweeping commands read one entry per cycle, then drain and close: the result is
// registered from the closing state, once the last entry read has been updated.
// A compare/subtract stage follows the registered memory read.
// Reset (synchronous) empties the bank; entry storage is not cleared.
// Results cannot be held off; each is shown for exactly one cycle.
`default_nettype none

module countdown_timer_bank (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire cdtb_pkg::req_t request,
  output logic               result_valid,
  output cdtb_pkg::rsp_t     result
);
  import cdtb_pkg::*;

  // Sequencer and control registers
  seq_state_t               state, state_next;
  req_t                     req_q, req_q_next;
  logic [CNT_W-1:0]         count, count_next;
  logic [CNT_W-1:0]         rd_cnt, rd_cnt_next;
  logic [CNT_W-1:0]         rd_end, rd_end_next;
  logic                     p_valid, p_valid_next;
  logic [IDX_W-1:0]         p_idx, p_idx_next;
  logic                     pend_valid, pend_valid_next;
  logic [IDX_W-1:0]         pend_idx, pend_idx_next;
  logic                     found, found_next;
  logic [IDX_W-1:0]         best_idx, best_idx_next;
  logic [DURATION_BITS-1:0] best_rem, best_rem_next;
  logic                     result_valid_next;
  rsp_t                     result_next;

  // Entry memory, one write and one registered read per cycle
  entry_t                   mem [TIMERS];
  entry_t                   rdata;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  entry_t                   wr_data;
  logic [IDX_W-1:0]         rd_addr;

  // Decode helpers
  logic                     slot_ok;
  logic                     is_full;
  logic                     direct;
  logic                     issue;
  entry_t                   new_entry;
  logic [DURATION_BITS-1:0] tick_rem;

  assign slot_ok = (32'(req_q.slot) < 32'(count));
  assign is_full = (count == CNT_W'(TIMERS));
  assign direct  = (req_q.cmd == CMD_ADD) || (req_q.cmd == CMD_EDIT) ||
                   (((req_q.cmd == CMD_REMOVE) || (req_q.cmd == CMD_START) ||
                     (req_q.cmd == CMD_PAUSE)) && !slot_ok);
  assign issue   = (state == SEQ_SWEEP) && (rd_cnt < rd_end);
  assign busy    = (state != SEQ_IDLE);
  assign rd_addr = rd_cnt[IDX_W-1:0];

  // Entry written by add and edit
  assign new_entry = '{duration:  DURATION_BITS'(req_q.duration),
                       remaining: DURATION_BITS'(req_q.duration),
                       status:    TMR_PAUSED,
                       group:     GROUP_BITS'(req_q.group_id)};

  // Saturating countdown of the entry under the sweep
  assign tick_rem = (32'(rdata.remaining) > 32'(req_q.elapsed)) ?
                    DURATION_BITS'(32'(rdata.remaining) - 32'(req_q.elapsed)) :
                    '0;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: begin
        if (start) begin
          state_next = SEQ_CMD;
        end
      end
      SEQ_CMD: begin
        state_next = direct ? SEQ_IDLE : SEQ_SWEEP;
      end
      SEQ_SWEEP: begin
        if (!issue && !p_valid) begin
          state_next = SEQ_DONE;
        end
      end
      SEQ_DONE: begin
        state_next = SEQ_IDLE;
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  // Datapath, memory port and result beats
  always_comb begin
    req_q_next        = req_q;
    count_next        = count;
    rd_cnt_next       = rd_cnt;
    rd_end_next       = rd_end;
    p_valid_next      = 1'b0;
    p_idx_next        = p_idx;
    pend_valid_next   = pend_valid;
    pend_idx_next     = pend_idx;
    found_next        = found;
    best_idx_next     = best_idx;
    best_rem_next     = best_rem;
    result_valid_next = 1'b0;
    result_next       = result;
    wr_en             = 1'b0;
    wr_addr           = p_idx;
    wr_data           = rdata;

    unique case (state)
      SEQ_IDLE: begin
        if (start) begin
          req_q_next = request;
        end
      end

      // Decode: finish short commands here, else set the sweep range
      SEQ_CMD: begin
        pend_valid_next = 1'b0;
        found_next      = 1'b0;
        unique case (req_q.cmd)
          CMD_ADD: begin
            result_valid_next = 1'b1;
            if (is_full) begin
              result_next = make_rsp(KIND_REJECTED, '0, '0, count, 1'b1);
            end else begin
              wr_en       = 1'b1;
              wr_addr     = count[IDX_W-1:0];
              wr_data     = new_entry;
              count_next  = count + 1'b1;
              result_next = make_rsp(KIND_DONE, '0, '0, count + 1'b1, 1'b1);
            end
          end
          CMD_EDIT: begin
            result_valid_next = 1'b1;
            if (slot_ok) begin
              wr_en       = 1'b1;
              wr_addr     = IDX_W'(req_q.slot);
              wr_data     = new_entry;
              result_next = make_rsp(KIND_DONE, '0, '0, count, 1'b1);
            end else begin
              result_next = make_rsp(KIND_REJECTED, '0, '0, count, 1'b1);
            end
          end
          CMD_REMOVE: begin
            if (slot_ok) begin
              rd_cnt_next = CNT_W'(32'(req_q.slot) + 1);
              rd_end_next = count;
            end else begin
              result_valid_next = 1'b1;
              result_next = make_rsp(KIND_REJECTED, '0, '0, count, 1'b1);
            end
          end
          CMD_START, CMD_PAUSE: begin
            if (slot_ok) begin
              rd_cnt_next = CNT_W'(req_q.slot);
              rd_end_next = CNT_W'(32'(req_q.slot) + 1);
            end else begin
              result_valid_next = 1'b1;
              result_next = make_rsp(KIND_REJECTED, '0, '0, count, 1'b1);
            end
          end
          CMD_TICK, CMD_START_GROUP, CMD_QUERY: begin
            rd_cnt_next = '0;
            rd_end_next = count;
          end
          default: ;
        endcase
      end

      // One entry read per cycle; the entry read last cycle is updated
      SEQ_SWEEP: begin
        if (issue) begin
          rd_cnt_next  = rd_cnt + 1'b1;
          p_valid_next = 1'b1;
          p_idx_next   = rd_cnt[IDX_W-1:0];
        end
        if (p_valid) begin
          unique case (req_q.cmd)
            CMD_REMOVE: begin
              // shift down by one
              wr_en   = 1'b1;
              wr_addr = p_idx - 1'b1;
            end
            CMD_START: begin
              wr_en   = 1'b1;
              wr_data = start_entry(rdata);
            end
            CMD_START_GROUP: begin
              if (rdata.group == GROUP_BITS'(req_q.group_id)) begin
                wr_en   = 1'b1;
                wr_data = start_entry(rdata);
              end
            end
            CMD_PAUSE: begin
              if (rdata.status == TMR_RUNNING) begin
                wr_en          = 1'b1;
                wr_data.status = TMR_PAUSED;
              end
            end
            CMD_TICK: begin
              if (rdata.status == TMR_RUNNING) begin
                wr_en             = 1'b1;
                wr_data.remaining = tick_rem;
                if (tick_rem == '0) begin
                  wr_data.status = TMR_FINISHED;
                  // hold the newest event back so the final one can carry last
                  if (pend_valid) begin
                    result_valid_next = 1'b1;
                    result_next = make_rsp(KIND_FINISHED, pend_idx, '0, count, 1'b0);
                  end
                  pend_valid_next = 1'b1;
                  pend_idx_next   = p_idx;
                end
              end
            end
            CMD_QUERY: begin
              if ((rdata.status == TMR_RUNNING) && (rdata.remaining != '0) &&
                  (!found || (rdata.remaining < best_rem))) begin
                found_next    = 1'b1;
                best_idx_next = p_idx;
                best_rem_next = rdata.remaining;
              end
            end
            default: ;
          endcase
        end
      end

      // Closing beat of a sweeping command
      SEQ_DONE: begin
        result_valid_next = 1'b1;
        unique case (req_q.cmd)
          CMD_REMOVE: begin
            count_next  = count - 1'b1;
            result_next = make_rsp(KIND_DONE, '0, '0, count - 1'b1, 1'b1);
          end
          CMD_TICK: begin
            if (pend_valid) begin
              result_next = make_rsp(KIND_FINISHED, pend_idx, '0, count, 1'b1);
            end else begin
              result_next = make_rsp(KIND_DONE, '0, '0, count, 1'b1);
            end
          end
          CMD_QUERY: begin
            if (found) begin
              result_next = make_rsp(KIND_NEXT, best_idx, best_rem, count, 1'b1);
            end else begin
              result_next = make_rsp(KIND_NONE, '0, '0, count, 1'b1);
            end
          end
          default: begin
            result_next = make_rsp(KIND_DONE, '0, '0, count, 1'b1);
          end
        endcase
      end

      default: ;
    endcase
  end

  // Entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= SEQ_IDLE;
      count        <= '0;
      p_valid      <= 1'b0;
      pend_valid   <= 1'b0;
      found        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      p_valid      <= p_valid_next;
      pend_valid   <= pend_valid_next;
      found        <= found_next;
      result_valid <= result_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_q    <= req_q_next;
    rd_cnt   <= rd_cnt_next;
    rd_end   <= rd_end_next;
    p_idx    <= p_idx_next;
    pend_idx <= pend_idx_next;
    best_idx <= best_idx_next;
    best_rem <= best_rem_next;
    result   <= result_next;
  end

endmodule

`default_nettype wire
